>>> rtl/core/rabe_pkg.sv
// rabe_pkg: shared types, register indexes and the byte substitution table
// for the reduced-round block encryptor. No dependencies.
package rabe_pkg;

  localparam int BLOCK_W = 128;
  localparam int IDX_W   = 8;

  localparam logic [IDX_W-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [IDX_W-1:0] REG_KEY_LOW  = 8'd1;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } block_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

endpackage

>>> rtl/core/reduced_aes_block_encrypt.sv
// reduced_aes_block_encrypt: top level, input key add stage, chain of round
// cells and the key expansion unit. Depends on rabe_pkg, rabe_cell and
// rabe_keysched.
//
// Usage: write key_high (index 0) and key_low (index 1) on the cfg channel;
// cfg_ready is always high. Each write restarts the key expansion, which
// runs one key column per cycle and holds busy high while it runs.
// The same expansion runs after reset with the all-zero key, so busy is
// high after rst drops until that expansion completes.
// An item is taken when start is high and busy is low. Items may follow in
// every cycle while busy is low: the input stage adds round key 0 and each
// of the ROUNDS cells does one round and registers it, so the chain holds up
// to ROUNDS+1 items at once. Throughput is one item per cycle while busy is low.
// An item taken passes the input stage register and then the ROUNDS cell
// registers in order, then shows on result with done high for exactly one
// cycle, in which the receiver takes it. The receiver cannot stall;
// results leave in the order items came in.
// The user must write keys only with no item in flight; the block does not enforce it.
module reduced_aes_block_encrypt #(
  parameter int ROUNDS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  rabe_pkg::block_t           block,
  output logic                       done,
  output rabe_pkg::cipher_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rabe_pkg::IDX_W-1:0] cfg_index,
  input  logic [63:0]                cfg_data
);
  import rabe_pkg::*;

  logic               accept;
  logic               cfg_we;
  logic               in_vld;
  logic [BLOCK_W-1:0] in_st;
  logic [BLOCK_W-1:0] rkey [0:ROUNDS];
  logic               vld [0:ROUNDS];
  logic [BLOCK_W-1:0] st  [0:ROUNDS];

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign accept    = start & ~busy;

  rabe_keysched #(
    .ROUNDS(ROUNDS)
  ) u_keysched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .rkey      (rkey)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_st <= {block.block_high, block.block_low} ^ rkey[0];
  end

  assign vld[0] = in_vld;
  assign st[0]  = in_st;

  for (genvar i = 1; i <= ROUNDS; i++) begin : g_round
    rabe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[i-1]),
      .state_in  (st[i-1]),
      .round_key (rkey[i]),
      .valid_out (vld[i]),
      .state_out (st[i])
    );
  end

  assign done               = vld[ROUNDS];
  assign result.cipher_high = st[ROUNDS][BLOCK_W-1 -: 64];
  assign result.cipher_low  = st[ROUNDS][63:0];

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |=> ##ROUNDS done)
    else $error("accepted item did not complete on time");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, ROUNDS + 1))
    else $error("result strobe without a matching item");

  a_cfg_restart : assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("key write did not restart key expansion");

endmodule

>>> rtl/core/rabe_cell.sv
// rabe_cell: one round of the cipher (byte substitution, row rotation,
// round key add) with its output register. Depends on rabe_pkg.
module rabe_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  logic [rabe_pkg::BLOCK_W-1:0] state_in,
  input  logic [rabe_pkg::BLOCK_W-1:0] round_key,
  output logic                        valid_out,
  output logic [rabe_pkg::BLOCK_W-1:0] state_out
);
  import rabe_pkg::*;

  logic [BLOCK_W-1:0] mixed;

  // byte k sits at row k%4, column k/4, byte 0 in the top bits
  always_comb begin
    mixed = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mixed[BLOCK_W-1-8*(4*c+r) -: 8] =
          sbox(state_in[BLOCK_W-1-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state_out <= mixed ^ round_key;
  end

endmodule

>>> rtl/core/rabe_keysched.sv
// rabe_keysched: key registers and a column-per-cycle key expansion that
// fills the round key store after reset and after each key write.
// Depends on rabe_pkg.
module rabe_keysched #(
  parameter int ROUNDS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rabe_pkg::IDX_W-1:0]  cfg_index,
  input  logic [63:0]                 cfg_data,
  output logic                        busy,
  output logic [rabe_pkg::BLOCK_W-1:0] rkey [0:ROUNDS]
);
  import rabe_pkg::*;

  localparam int RW = $clog2(ROUNDS + 1);

  logic [63:0]        key_high;
  logic [63:0]        key_low;
  logic               pend;
  logic               running;
  logic [1:0]         col;
  logic [RW-1:0]      round;
  logic [7:0]         rcon;
  logic [BLOCK_W-1:0] win;
  logic [BLOCK_W-1:0] rk_store [1:ROUNDS];
  logic [31:0]        prev_rot;
  logic [31:0]        sub;
  logic [31:0]        newcol;
  logic [BLOCK_W-1:0] win_next;

  // window holds the last four columns, oldest in the top bits
  always_comb begin
    prev_rot = {win[23:0], win[31:24]};
    for (int b = 0; b < 4; b++) begin
      sub[8*b +: 8] = sbox(prev_rot[8*b +: 8]);
    end
    newcol   = sub ^ {rcon, 24'h0} ^ win[BLOCK_W-1 -: 32];
    win_next = {win[BLOCK_W-33:0], newcol};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      pend     <= 1'b1;
      running  <= 1'b0;
      col      <= '0;
      round    <= '0;
      rcon     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_HIGH) begin
          key_high <= cfg_data;
        end else if (cfg_index == REG_KEY_LOW) begin
          key_low <= cfg_data;
        end
      end
      if (cfg_we) begin
        pend    <= 1'b1;
        running <= 1'b0;
      end else if (pend) begin
        pend    <= 1'b0;
        running <= 1'b1;
        col     <= '0;
        round   <= RW'(1);
        rcon    <= 8'h01;
      end else if (running) begin
        col <= col + 2'd1;
        if (col == 2'd3) begin
          rcon <= {rcon[6:0], 1'b0};
          if (round == RW'(ROUNDS)) begin
            running <= 1'b0;
          end else begin
            round <= round + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      win <= {key_high, key_low};
    end else if (running) begin
      win <= win_next;
    end
    // completed round keys shift down so that round 1 ends at the bottom
    if (!pend && running && col == 2'd3) begin
      for (int i = 1; i < ROUNDS; i++) begin
        rk_store[i] <= rk_store[i+1];
      end
      rk_store[ROUNDS] <= win_next;
    end
  end

  always_comb begin
    rkey[0] = {key_high, key_low};
    for (int i = 1; i <= ROUNDS; i++) begin
      rkey[i] = rk_store[i];
    end
  end

  assign busy = pend | running;

endmodule

>>> test/tb.sv
// tb: self-checking bench for reduced_aes_block_encrypt, with directed and random blocks
// and key changes checked against an in-bench cipher predictor.
// Depends on rabe_pkg and the reduced_aes_block_encrypt RTL.
module tb;
  import rabe_pkg::*;

  localparam int ROUNDS = 8;
  localparam int KEY_COLS = 4 * (ROUNDS + 1);
  localparam int PHASES = 14;
  localparam int BLOCKS_PER_PHASE = 125;
  localparam int CYCLE_LIMIT = 200000;

  class cipher_scoreboard;
    logic [7:0] sub_table [256];
    logic [63:0] key_high;
    logic [63:0] key_low;
    cipher_t expected_ciphers [$];
    int errors;

    function new();
      logic [7:0] inv;
      key_high = '0;
      key_low = '0;
      errors = 0;
      // s-box built from the field inverse and the affine map
      for (int x = 0; x < 256; x++) begin
        inv = 8'h00;
        for (int y = 1; y < 256; y++) begin
          if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
        end
        sub_table[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^
                       rotl8(inv, 4) ^ 8'h63;
      end
    endfunction

    function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) p ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
    endfunction

    function logic [7:0] rotl8(logic [7:0] v, int n);
      return (v << n) | (v >> (8 - n));
    endfunction

    function void write_key(logic [IDX_W-1:0] idx, logic [63:0] data);
      if (idx == REG_KEY_HIGH) begin
        key_high = data;
      end else if (idx == REG_KEY_LOW) begin
        key_low = data;
      end
    endfunction

    function cipher_t encipher_block(block_t b);
      logic [7:0] kb [16];
      logic [7:0] st [16];
      logic [7:0] sh [16];
      logic [7:0] sched [KEY_COLS][4];
      logic [7:0] tw [4];
      logic [7:0] rc;
      int e;
      cipher_t res;
      for (int k = 0; k < 8; k++) begin
        kb[k] = key_high[63-8*k -: 8];
        kb[k+8] = key_low[63-8*k -: 8];
        st[k] = b.block_high[63-8*k -: 8];
        st[k+8] = b.block_low[63-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) sched[c][r] = kb[4*c+r];
      end
      // every column past the key gets rotate, substitute and round constant
      for (int c = 4; c < KEY_COLS; c++) begin
        e = c / 4 - 1;
        rc = (e < 8) ? (8'h01 << e) : 8'h00;
        for (int r = 0; r < 4; r++) tw[r] = sub_table[sched[c-1][(r+1)%4]];
        tw[0] ^= rc;
        for (int r = 0; r < 4; r++) sched[c][r] = tw[r] ^ sched[c-4][r];
      end
      for (int k = 0; k < 16; k++) st[k] ^= sched[k/4][k%4];
      for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) sh[4*c+r] = sub_table[st[4*((c+r)%4)+r]];
        end
        for (int k = 0; k < 16; k++) st[k] = sh[k] ^ sched[4*rnd + k/4][k%4];
      end
      for (int k = 0; k < 8; k++) begin
        res.cipher_high[63-8*k -: 8] = st[k];
        res.cipher_low[63-8*k -: 8] = st[k+8];
      end
      return res;
    endfunction

    function void note_block(block_t b);
      expected_ciphers.push_back(encipher_block(b));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_cipher(cipher_t got);
      cipher_t want;
      if (expected_ciphers.size() == 0) begin
        report_mismatch("cipher with no item pending", got.cipher_high, got.cipher_low);
        return;
      end
      want = expected_ciphers.pop_front();
      if (got.cipher_high !== want.cipher_high)
        report_mismatch("cipher_high", got.cipher_high, want.cipher_high);
      if (got.cipher_low !== want.cipher_low)
        report_mismatch("cipher_low", got.cipher_low, want.cipher_low);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  block_t block = '0;
  logic done;
  cipher_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  cipher_scoreboard sb;
  int burst_left = 1;
  bit gaps_on = 1'b1;

  reduced_aes_block_encrypt #(.ROUNDS(ROUNDS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .block(block),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_cipher(result);
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // start stays high across a burst, drops only for a gap
  task send_block(input block_t b);
    start <= 1'b1;
    block <= b;
    do @(posedge clk); while (busy);
    sb.note_block(b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 32);
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task send_words(input logic [63:0] hi, input logic [63:0] lo);
    block_t b;
    b.block_high = hi;
    b.block_low = lo;
    send_block(b);
  endtask

  // caller lowers cfg_valid after the last write of a series
  task write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_key(idx, data);
  endtask

  task drain_pipeline();
    start <= 1'b0;
    while (sb.expected_ciphers.size() != 0) @(posedge clk);
    repeat (ROUNDS + 4) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [IDX_W-1:0] stray_idx;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset key is all zero
    send_words('0, '0);
    send_words('1, '1);
    send_words(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_pipeline();

    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '0);
    cfg_valid <= 1'b0;
    send_words('0, '0);
    send_words('1, '1);
    drain_pipeline();

    // writes to unused indexes must leave the key alone
    stray_idx = 8'hff;
    write_reg(REG_KEY_LOW, '1);
    write_reg(stray_idx, 64'h5a5a5a5a5a5a5a5a);
    stray_idx = 8'h02;
    write_reg(stray_idx, '0);
    cfg_valid <= 1'b0;
    send_words('0, '1);
    send_words('1, '0);
    send_words(64'h8000000000000001, 64'h0000000180000000);
    drain_pipeline();

    write_reg(REG_KEY_HIGH, '0);
    write_reg(REG_KEY_LOW, 64'h0001020304050607);
    cfg_valid <= 1'b0;
    send_words(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_words(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_words(64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00);
    send_words(64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0);
    drain_pipeline();

    for (int ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph % 3) != 0;
      case ($urandom_range(0, 3))
        0: write_reg(REG_KEY_HIGH, rand_word());
        1: write_reg(REG_KEY_LOW, rand_word());
        2: begin
          write_reg(REG_KEY_HIGH, rand_word());
          write_reg(REG_KEY_LOW, rand_word());
        end
        default: begin
          write_reg(REG_KEY_LOW, rand_word());
          stray_idx = IDX_W'($urandom_range(2, 255));
          write_reg(stray_idx, rand_word());
          write_reg(REG_KEY_HIGH, rand_word());
        end
      endcase
      cfg_valid <= 1'b0;
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) send_words(rand_word(), rand_word());
      drain_pipeline();
    end

    if (sb.errors == 0 && sb.expected_ciphers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
